/* hw/rtl/etq_pkg.sv */
// ---------------------------------------------------------------------------
// etq_pkg
// Shared types, codes and sizes for the expiry timeout queue.
// ---------------------------------------------------------------------------
`default_nettype none

package etq_pkg;

    localparam int ENTRIES  = 32;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int HANDLE_W = 5;
    localparam int TIME_W   = 32;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd600;

    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_TOUCH      = 2'd1;
    localparam logic [1:0] OP_DEREGISTER = 2'd2;
    localparam logic [1:0] OP_COLLECT    = 2'd3;

    localparam logic [1:0] RK_ACK     = 2'd0;
    localparam logic [1:0] RK_EXPIRED = 2'd1;
    localparam logic [1:0] RK_SUMMARY = 2'd2;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_ALREADY = 2'd1;
    localparam logic [1:0] STS_NOT_REG = 2'd2;

    localparam logic [2:0] EMIT_NONE    = 3'd0;
    localparam logic [2:0] EMIT_ACK_OK  = 3'd1;
    localparam logic [2:0] EMIT_ACK_DUP = 3'd2;
    localparam logic [2:0] EMIT_ACK_NRG = 3'd3;
    localparam logic [2:0] EMIT_EXPIRED = 3'd4;
    localparam logic [2:0] EMIT_SUMMARY = 3'd5;

    typedef logic [IDX_W-1:0] slot_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [HANDLE_W-1:0] handle;
        logic [1:0]          cleanup_kind;
        logic [TIME_W-1:0]   now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          result_kind;
        logic [1:0]          status;
        logic [HANDLE_W-1:0] entry;
        logic [1:0]          expired_kind;
        logic                pending;
        logic [TIME_W-1:0]   wait_seconds;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic       latch;
        logic       rd_links;
        logic       rd_head;
        logic       do_register;
        logic       do_unlink;
        logic       do_link;
        logic       pop_head;
        logic [2:0] emit;
    } etq_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       in_range;
        logic       hit;
        logic       empty;
        logic       expired;
        logic       out_free;
    } etq_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/etq_ram.sv */
// ---------------------------------------------------------------------------
// etq_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module etq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/etq_ctrl.sv */
// ---------------------------------------------------------------------------
// etq_ctrl
// Sequencer for the expiry timeout queue: decodes each request and steps
// the datapath through link updates and the collect walk.
// ---------------------------------------------------------------------------
`default_nettype none

module etq_ctrl
    import etq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire etq_stat_t stat,
    output etq_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_UNLINK    = 3'd2;
    localparam logic [2:0] S_LINK      = 3'd3;
    localparam logic [2:0] S_ACK       = 3'd4;
    localparam logic [2:0] S_COL_CHECK = 3'd5;
    localparam logic [2:0] S_COL_EVAL  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = EMIT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_REGISTER:
                    begin
                        if (stat.out_free)
                        begin
                            if (!stat.in_range)
                            begin
                                cmd.emit = EMIT_ACK_NRG;
                            end
                            else if (stat.hit)
                            begin
                                cmd.emit = EMIT_ACK_DUP;
                            end
                            else
                            begin
                                cmd.emit        = EMIT_ACK_OK;
                                cmd.do_register = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    OP_TOUCH, OP_DEREGISTER:
                    begin
                        if (stat.hit)
                        begin
                            cmd.rd_links = 1'b1;
                            state_next   = S_UNLINK;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit   = EMIT_ACK_NRG;
                            state_next = S_IDLE;
                        end
                    end
                    OP_COLLECT:
                    begin
                        state_next = S_COL_CHECK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_UNLINK:
            begin
                cmd.do_unlink = 1'b1;
                state_next    = (stat.op == OP_TOUCH) ? S_LINK : S_ACK;
            end
            S_LINK:
            begin
                cmd.do_link = 1'b1;
                state_next  = S_ACK;
            end
            S_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = EMIT_ACK_OK;
                    state_next = S_IDLE;
                end
            end
            S_COL_CHECK:
            begin
                if (!stat.empty)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_COL_EVAL;
                end
                else if (stat.out_free)
                begin
                    cmd.emit   = EMIT_SUMMARY;
                    state_next = S_IDLE;
                end
            end
            S_COL_EVAL:
            begin
                if (stat.out_free)
                begin
                    if (stat.expired)
                    begin
                        cmd.emit     = EMIT_EXPIRED;
                        cmd.pop_head = 1'b1;
                        state_next   = S_COL_CHECK;
                    end
                    else
                    begin
                        cmd.emit   = EMIT_SUMMARY;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/etq_dp.sv */
// ---------------------------------------------------------------------------
// etq_dp
// Datapath of the expiry timeout queue: request latch, timeout register,
// valid bits, list pointers, entry memories and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module etq_dp
    import etq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [TIME_W-1:0] cfg_wdata,
    input  wire in_item_t          in_item,
    input  wire etq_cmd_t          cmd,
    output etq_stat_t              stat,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_item
);

    in_item_t          item_reg;
    logic [TIME_W-1:0] timeout_reg;
    logic [ENTRIES-1:0] valid_bits_reg, valid_bits_next;
    slot_t             head_reg, head_next;
    slot_t             tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    slot_t             h_ix;
    logic              in_range;
    logic [TIME_W:0]   dl_sum;
    logic [TIME_W-1:0] new_dl;
    logic [CNT_W-1:0]  count_dec;

    logic              dl_we, kind_we, next_we, prev_we;
    slot_t             next_waddr, next_wdata, prev_waddr, prev_wdata;
    slot_t             next_raddr;
    logic [TIME_W-1:0] dl_rdata;
    logic [1:0]        kind_rdata;
    slot_t             next_rdata, prev_rdata;
    logic              out_free;

    assign h_ix      = IDX_W'(item_reg.handle);
    assign in_range  = (32'(item_reg.handle) < ENTRIES);
    assign dl_sum    = {1'b0, item_reg.now_seconds} + {1'b0, timeout_reg};
    assign new_dl    = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
    assign count_dec = count_reg - CNT_W'(1);
    assign out_free  = !out_valid_reg || out_ready;

    assign stat.op       = item_reg.op;
    assign stat.in_range = in_range;
    assign stat.hit      = in_range && valid_bits_reg[h_ix];
    assign stat.empty    = (count_reg == '0);
    assign stat.expired  = (dl_rdata < item_reg.now_seconds);
    assign stat.out_free = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= in_item;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            valid_bits_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            valid_bits_reg <= valid_bits_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // list pointer and memory write control
    always_comb
    begin
        valid_bits_next = valid_bits_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        dl_we           = 1'b0;
        kind_we         = 1'b0;
        next_we         = 1'b0;
        prev_we         = 1'b0;
        next_waddr      = tail_reg;
        next_wdata      = h_ix;
        prev_waddr      = h_ix;
        prev_wdata      = tail_reg;
        next_raddr      = cmd.rd_head ? head_reg : h_ix;

        if (cmd.do_register || cmd.do_link)
        begin
            dl_we   = 1'b1;
            kind_we = cmd.do_register;
            if (cmd.do_register)
            begin
                valid_bits_next[h_ix] = 1'b1;
            end
            if (count_reg == '0)
            begin
                head_next = h_ix;
            end
            else
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            tail_next  = h_ix;
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.do_unlink)
        begin
            next_waddr = prev_rdata;
            next_wdata = next_rdata;
            prev_waddr = next_rdata;
            prev_wdata = prev_rdata;
            if (h_ix == head_reg)
            begin
                head_next = next_rdata;
            end
            else
            begin
                next_we = 1'b1;
            end
            if (h_ix == tail_reg)
            begin
                tail_next = prev_rdata;
            end
            else
            begin
                prev_we = 1'b1;
            end
            count_next = count_dec;
            if (count_dec == '0)
            begin
                head_next = '0;
                tail_next = '0;
            end
            if (item_reg.op == OP_DEREGISTER)
            begin
                valid_bits_next[h_ix] = 1'b0;
            end
        end

        if (cmd.pop_head)
        begin
            valid_bits_next[head_reg] = 1'b0;
            head_next  = next_rdata;
            count_next = count_dec;
            if (count_dec == '0)
            begin
                head_next = '0;
                tail_next = '0;
            end
        end
    end

    // result formatting
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.emit != EMIT_NONE)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
        end
        unique case (cmd.emit)
            EMIT_NONE:
            begin
            end
            EMIT_ACK_OK, EMIT_ACK_DUP, EMIT_ACK_NRG:
            begin
                out_next.result_kind = RK_ACK;
                out_next.entry       = item_reg.handle;
                out_next.last        = 1'b1;
                if (cmd.emit == EMIT_ACK_DUP)
                begin
                    out_next.status = STS_ALREADY;
                end
                else if (cmd.emit == EMIT_ACK_NRG)
                begin
                    out_next.status = STS_NOT_REG;
                end
                else
                begin
                    out_next.status = STS_OK;
                end
            end
            EMIT_EXPIRED:
            begin
                out_next.result_kind  = RK_EXPIRED;
                out_next.entry        = HANDLE_W'(head_reg);
                out_next.expired_kind = kind_rdata;
            end
            EMIT_SUMMARY:
            begin
                out_next.result_kind = RK_SUMMARY;
                out_next.last        = 1'b1;
                if (count_reg != '0)
                begin
                    out_next.pending      = 1'b1;
                    out_next.wait_seconds = dl_rdata - item_reg.now_seconds;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
                out_next       = out_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    etq_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_dl_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (h_ix),
        .wdata (new_dl),
        .re    (cmd.rd_head),
        .raddr (head_reg),
        .rdata (dl_rdata)
    );

    etq_ram #(.WIDTH(2), .DEPTH(ENTRIES)) u_kind_ram (
        .clk   (clk),
        .we    (kind_we),
        .waddr (h_ix),
        .wdata (item_reg.cleanup_kind),
        .re    (cmd.rd_head),
        .raddr (head_reg),
        .rdata (kind_rdata)
    );

    etq_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (cmd.rd_head || cmd.rd_links),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    etq_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (cmd.rd_links),
        .raddr (h_ix),
        .rdata (prev_rdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/expiry_timeout_queue_top.sv */
// ---------------------------------------------------------------------------
// expiry_timeout_queue_top
// Aging queue of up to 32 tracked slots kept in insertion order.
//
// Requests arrive on in_valid/in_ready/in_item: register, touch, deregister
// or collect. Results leave on out_valid/out_ready/out_item, one ack per
// register, touch or deregister, and for a collect one result per expired
// head slot followed by a summary; the final result of a request has last set.
// The user must write the timeout through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. One request is
// handled at a time. Register and failed requests load their ack in the
// decode state, deregister after unlink, touch after unlink and link; the
// next request is taken in the cycle after its ack is loaded. Collect pops
// expired head slots one by one, each read from the deadline and link
// memories, and loads its summary on an empty queue or an unexpired head.
// A result waits in the output register while out_ready is low; the
// sequencer holds until that register is free, and in_ready stays low.
// Reset empties the queue, clears all valid bits and sets the timeout to 600.
// ---------------------------------------------------------------------------
`default_nettype none

module expiry_timeout_queue_top
    import etq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [TIME_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_item
);

    etq_cmd_t  cmd;
    etq_stat_t stat;

    etq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    etq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
